@@ design/bup2_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bup2_pkg
// Shared types, constants and helper functions of the 2x bilinear RGB
// upscaler.
// ----------------------------------------------------------------------------
package bup2_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W = 11;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  typedef logic [3*CHAN_W-1:0] pix_t;

  typedef enum logic [2:0] {
    STEP_UP0,
    STEP_UP1,
    STEP_EVEN0,
    STEP_EVEN1,
    STEP_LOW0,
    STEP_LOW1
  } step_t;

  typedef struct packed {
    pix_t             cur;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             have_up;
    logic             last_row;
    logic             last_col;
  } item_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    pix_t             wdata;
  } mem_req_t;

  function automatic pix_t mid(input pix_t a, input pix_t b);
    pix_t res;
    for (int i = 0; i < 3; i++) begin
      res[i*CHAN_W +: CHAN_W] = (a[i*CHAN_W +: CHAN_W] >> 1) + (b[i*CHAN_W +: CHAN_W] >> 1);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ design/bup2_line_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bup2_line_store
// Single-port line memory holding the previous input row. A port access
// writes the new pixel and returns the old contents on its registered read port in the next cycle.
// ----------------------------------------------------------------------------
module bup2_line_store (
  input  wire logic             clk,
  input  wire bup2_pkg::mem_req_t req,
  output      bup2_pkg::pix_t   rdata_r
);
  import bup2_pkg::*;

  pix_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      mem[req.addr] <= req.wdata;
      rdata_r       <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

@@ design/bup2_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bup2_front
// Configuration registers, frame position counters and the input stage.
// Each accepted pixel issues a read-and-write of its column in the line store.
// ----------------------------------------------------------------------------
module bup2_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [bup2_pkg::CHAN_W-1:0] in_red,
  input  wire logic [bup2_pkg::CHAN_W-1:0] in_green,
  input  wire logic [bup2_pkg::CHAN_W-1:0] in_blue,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [bup2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bup2_pkg::DIM_W-1:0]  cfg_data,
  input  wire logic                        take,
  output      bup2_pkg::item_t             item_r,
  output      logic                        item_valid_r,
  output      bup2_pkg::mem_req_t          mem_req
);
  import bup2_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             item_valid_nxt;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0] c;
  logic [ROW_W-1:0] r;
  logic             last_col, last_row, accept, cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !item_valid_r || take;
  assign accept    = in_valid && in_ready;

  always_comb begin
    w_eff = width_r;
    if (width_r < DIM_W'(2)) w_eff = DIM_W'(2);
    if (width_r > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = height_r;
    if (height_r < DIM_W'(1)) h_eff = DIM_W'(1);
    if (height_r > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    c = (DIM_W'(col_r) >= w_eff) ? '0 : col_r;
    r = (DIM_W'(row_r) >= h_eff) ? '0 : row_r;
    last_col = (DIM_W'(c) + DIM_W'(1)) == w_eff;
    last_row = (DIM_W'(r) + DIM_W'(1)) == h_eff;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : r + ROW_W'(1);
      end else begin
        col_nxt = c + COL_W'(1);
        row_nxt = r;
      end
    end
    if (accept) begin
      item_valid_nxt = 1'b1;
    end else if (take) begin
      item_valid_nxt = 1'b0;
    end else begin
      item_valid_nxt = item_valid_r;
    end
  end

  always_comb begin
    mem_req.en    = accept;
    mem_req.addr  = c;
    mem_req.wdata = {in_red, in_green, in_blue};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= WIDTH_RESET;
      height_r     <= HEIGHT_RESET;
      col_r        <= '0;
      row_r        <= '0;
      item_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      item_valid_r <= item_valid_nxt;
      if (cfg_wr && cfg_index == CFG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_wr && cfg_index == CFG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.cur      <= {in_red, in_green, in_blue};
      item_r.col      <= c;
      item_r.row      <= r;
      item_r.have_up  <= (r != '0);
      item_r.last_row <= last_row;
      item_r.last_col <= last_col;
    end
  end

endmodule
`default_nettype wire

@@ design/bup2_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bup2_emit
// Result sequencer. Holds the current pixel with its left and upper
// neighbors, steps through the column pairs it completes and feeds one
// interpolated word per cycle into the output register while the output is not stalled.
// ----------------------------------------------------------------------------
module bup2_emit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bup2_pkg::item_t             item,
  input  wire logic                        item_valid,
  input  wire bup2_pkg::pix_t              up_data,
  output      logic                        take,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [bup2_pkg::DIM_W-1:0]  out_col,
  output      logic [bup2_pkg::DIM_W-1:0]  out_row,
  output      logic [bup2_pkg::CHAN_W-1:0] out_red,
  output      logic [bup2_pkg::CHAN_W-1:0] out_green,
  output      logic [bup2_pkg::CHAN_W-1:0] out_blue,
  output      logic                        out_run_last,
  output      logic                        out_frame_done
);
  import bup2_pkg::*;

  item_t b_r;
  pix_t  left_r, ul_r, up_r;
  logic  busy_r, busy_nxt;
  logic  pair_r, pair_nxt;
  step_t step_r, step_nxt;

  logic             out_valid_r;
  logic [DIM_W-1:0] col_out_r, row_out_r;
  pix_t             pix_out_r;
  logic             run_last_r, frame_done_r;

  logic             out_free, fire, last_step, final_word;
  step_t            first_step, end_step, load_first;
  logic [COL_W-1:0] k;
  pix_t             lp, rp, ulp, urp, e0, e1, u0, u1, pix;
  logic [DIM_W-1:0] c0, c1, r_even, r_up, r_low, col_sel, row_sel;

  assign out_free   = !out_valid_r || out_ready;
  assign fire       = busy_r && out_free;
  assign first_step = b_r.have_up ? STEP_UP0 : STEP_EVEN0;
  assign end_step   = b_r.last_row ? STEP_LOW1 : STEP_EVEN1;
  assign load_first = item.have_up ? STEP_UP0 : STEP_EVEN0;
  assign last_step  = (step_r == end_step);
  assign final_word = last_step && (pair_r || !b_r.last_col);
  assign take       = item_valid && (!busy_r || (fire && final_word));

  always_comb begin
    k   = pair_r ? b_r.col : b_r.col - COL_W'(1);
    lp  = pair_r ? b_r.cur : left_r;
    rp  = b_r.cur;
    ulp = pair_r ? up_r : ul_r;
    urp = up_r;
    e0  = lp;
    e1  = mid(lp, rp);
    u0  = ulp;
    u1  = mid(ulp, urp);
    c0  = {k, 1'b0};
    c1  = {k, 1'b1};
    r_even = {b_r.row, 1'b0};
    r_up   = r_even - DIM_W'(1);
    r_low  = {b_r.row, 1'b1};
    case (step_r)
      STEP_UP0: begin
        col_sel = c0;
        row_sel = r_up;
        pix     = mid(u0, e0);
      end
      STEP_UP1: begin
        col_sel = c1;
        row_sel = r_up;
        pix     = mid(u1, e1);
      end
      STEP_EVEN0: begin
        col_sel = c0;
        row_sel = r_even;
        pix     = e0;
      end
      STEP_EVEN1: begin
        col_sel = c1;
        row_sel = r_even;
        pix     = e1;
      end
      STEP_LOW0: begin
        col_sel = c0;
        row_sel = r_low;
        pix     = mid(e0, e0);
      end
      STEP_LOW1: begin
        col_sel = c1;
        row_sel = r_low;
        pix     = mid(e1, e1);
      end
      default: begin
        col_sel = c0;
        row_sel = r_even;
        pix     = e0;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pair_nxt = pair_r;
    step_nxt = step_r;
    if (take) begin
      busy_nxt = (item.col != '0);
      pair_nxt = 1'b0;
      step_nxt = load_first;
    end else if (fire) begin
      if (last_step) begin
        if (final_word) begin
          busy_nxt = 1'b0;
        end else begin
          pair_nxt = 1'b1;
          step_nxt = first_step;
        end
      end else begin
        step_nxt = step_t'(step_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pair_r      <= 1'b0;
      step_r      <= STEP_EVEN0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      pair_r <= pair_nxt;
      step_r <= step_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_r    <= item;
      left_r <= b_r.cur;
      ul_r   <= up_r;
      up_r   <= up_data;
    end
    if (fire) begin
      col_out_r    <= col_sel;
      row_out_r    <= row_sel;
      pix_out_r    <= pix;
      run_last_r   <= final_word;
      frame_done_r <= final_word && b_r.last_row && b_r.last_col;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_col        = col_out_r;
  assign out_row        = row_out_r;
  assign out_red        = pix_out_r[3*CHAN_W-1:2*CHAN_W];
  assign out_green      = pix_out_r[2*CHAN_W-1:CHAN_W];
  assign out_blue       = pix_out_r[CHAN_W-1:0];
  assign out_run_last   = run_last_r;
  assign out_frame_done = frame_done_r;

endmodule
`default_nettype wire

@@ design/bilinear_rgb_upscale_by_two_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_rgb_upscale_by_two_unit
// Streaming 2x bilinear upscaler for RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter one word per cycle at most, when the input stage is free, and
// each output word leaves one per cycle through a registered output stage
// while out_ready does not stall it. A pixel at column zero produces no word,
// an inner pixel two to six, and the last pixel of a row up to twelve. The
// previous row lives in a single-port line store that is read and written in
// the cycle a pixel is accepted; its contents need no clearing after reset.
// Writing image_width or image_height restarts the frame at its first pixel.
module bilinear_rgb_upscale_by_two_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [bup2_pkg::CHAN_W-1:0]    in_red,
  input  wire logic [bup2_pkg::CHAN_W-1:0]    in_green,
  input  wire logic [bup2_pkg::CHAN_W-1:0]    in_blue,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [bup2_pkg::DIM_W-1:0]     out_col,
  output      logic [bup2_pkg::DIM_W-1:0]     out_row,
  output      logic [bup2_pkg::CHAN_W-1:0]    out_red,
  output      logic [bup2_pkg::CHAN_W-1:0]    out_green,
  output      logic [bup2_pkg::CHAN_W-1:0]    out_blue,
  output      logic                           out_run_last,
  output      logic                           out_frame_done,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [bup2_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bup2_pkg::DIM_W-1:0]     cfg_data
);
  import bup2_pkg::*;

  item_t    item;
  logic     item_valid, take;
  mem_req_t mem_req;
  pix_t     up_data;

  bup2_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .item_r       (item),
    .item_valid_r (item_valid),
    .mem_req      (mem_req)
  );

  bup2_line_store u_line_store (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (up_data)
  );

  bup2_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .item           (item),
    .item_valid     (item_valid),
    .up_data        (up_data),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_bilinear_rgb_upscale_by_two_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_rgb_upscale_by_two_unit
// Self-checking testbench for the streaming 2x bilinear RGB upscaler. Pixels
// go in through the input channel under random stalls on both sides. An
// in-bench model of the line store, the neighbor registers and the frame
// counters predicts every tagged output word, and each word is compared field
// by field as it leaves the block. Directed tests cover reset sizes, channel
// extremes, size clamping and frame restarts. Random frames and the largest
// frame sizes follow.
// ----------------------------------------------------------------------------
module tb_bilinear_rgb_upscale_by_two_unit;

  localparam int CLK_PERIOD   = 12;
  localparam int DRAIN_CYCLES = 16;
  localparam int LIMIT_CYCLES = 600000;
  localparam int WORDS_MAX    = 12;
  localparam int EDGE_PIXELS  = 24;

  localparam logic [bup2_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [bup2_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [bup2_pkg::DIM_W-1:0] col;
    logic [bup2_pkg::DIM_W-1:0] row;
    bup2_pkg::pix_t             px;
    logic                       run_last;
    logic                       frame_done;
  } out_word_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [bup2_pkg::CHAN_W-1:0]     in_red = '0;
  logic [bup2_pkg::CHAN_W-1:0]     in_green = '0;
  logic [bup2_pkg::CHAN_W-1:0]     in_blue = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [bup2_pkg::DIM_W-1:0]      out_col;
  logic [bup2_pkg::DIM_W-1:0]      out_row;
  logic [bup2_pkg::CHAN_W-1:0]     out_red;
  logic [bup2_pkg::CHAN_W-1:0]     out_green;
  logic [bup2_pkg::CHAN_W-1:0]     out_blue;
  logic                            out_run_last;
  logic                            out_frame_done;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bup2_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bup2_pkg::DIM_W-1:0]      cfg_data = '0;

  // Model state of the upscaler.
  bup2_pkg::pix_t             line_mem [bup2_pkg::MAX_WIDTH];
  bup2_pkg::pix_t             left_px = '0;
  bup2_pkg::pix_t             upper_left_px = '0;
  int                         col_pos = 0;
  int                         row_pos = 0;
  logic [bup2_pkg::DIM_W-1:0] width_reg = bup2_pkg::WIDTH_RESET;
  logic [bup2_pkg::DIM_W-1:0] height_reg = bup2_pkg::HEIGHT_RESET;

  out_word_t upscaled_px_q[$];
  out_word_t batch_px [WORDS_MAX];
  int        batch_n = 0;
  out_word_t seen_px;
  out_word_t want_px;

  int err_count = 0;
  int pixels_sent = 0;
  int words_checked = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  bilinear_rgb_upscale_by_two_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d words still outstanding.", upscaled_px_q.size());
    $display("** bilinear_rgb_upscale_by_two_unit: FAILED **");
    $finish;
  end

  function automatic bup2_pkg::pix_t halve_sum(bup2_pkg::pix_t a, bup2_pkg::pix_t b);
    return ((a >> 1) & 24'h7F7F7F) + ((b >> 1) & 24'h7F7F7F);
  endfunction

  function automatic void add_word(int col, int row, bup2_pkg::pix_t px);
    out_word_t w;
    w.col = 11'(col);
    w.row = 11'(row);
    w.px = px;
    w.run_last = 1'b0;
    w.frame_done = 1'b0;
    batch_px[batch_n] = w;
    batch_n++;
  endfunction

  function automatic void add_pair(int k, int r, bup2_pkg::pix_t lp, bup2_pkg::pix_t rp,
                                   bup2_pkg::pix_t ulp, bup2_pkg::pix_t urp,
                                   bit have_up, bit last_row);
    bup2_pkg::pix_t e0;
    bup2_pkg::pix_t e1;
    e0 = lp;
    e1 = halve_sum(lp, rp);
    if (have_up) begin
      add_word(2 * k, 2 * r - 1, halve_sum(ulp, e0));
      add_word(2 * k + 1, 2 * r - 1, halve_sum(halve_sum(ulp, urp), e1));
    end
    add_word(2 * k, 2 * r, e0);
    add_word(2 * k + 1, 2 * r, e1);
    if (last_row) begin
      add_word(2 * k, 2 * r + 1, halve_sum(e0, e0));
      add_word(2 * k + 1, 2 * r + 1, halve_sum(e1, e1));
    end
  endfunction

  function automatic void upscale_pixel(bup2_pkg::pix_t cur);
    int             w;
    int             h;
    int             c;
    int             r;
    bup2_pkg::pix_t above;
    bit             last_row;
    bit             last_col;
    out_word_t      tail;
    w = width_reg;
    h = height_reg;
    if (w < 2) w = 2;
    if (w > bup2_pkg::MAX_WIDTH) w = bup2_pkg::MAX_WIDTH;
    if (h < 1) h = 1;
    if (h > bup2_pkg::MAX_HEIGHT) h = bup2_pkg::MAX_HEIGHT;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    above = line_mem[c];
    last_row = (r + 1 == h);
    last_col = (c + 1 == w);
    batch_n = 0;
    if (c >= 1) begin
      add_pair(c - 1, r, left_px, cur, upper_left_px, above, r >= 1, last_row);
      if (last_col) add_pair(c, r, cur, cur, above, above, r >= 1, last_row);
    end
    upper_left_px = above;
    left_px = cur;
    line_mem[c] = cur;
    if (batch_n > 0) begin
      tail = batch_px[batch_n - 1];
      tail.run_last = 1'b1;
      tail.frame_done = last_row && last_col;
      batch_px[batch_n - 1] = tail;
    end
    for (int i = 0; i < batch_n; i++) upscaled_px_q.push_back(batch_px[i]);
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic void apply_cfg(logic [bup2_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bup2_pkg::DIM_W-1:0] value);
    if (idx == bup2_pkg::CFG_IMAGE_WIDTH) begin
      width_reg = value;
    end else if (idx == bup2_pkg::CFG_IMAGE_HEIGHT) begin
      height_reg = value;
    end else begin
      return;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic bup2_pkg::pix_t random_pixel();
    bup2_pkg::pix_t p;
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(7))
        0: p[i*8 +: 8] = 8'h00;
        1: p[i*8 +: 8] = 8'hFF;
        default: p[i*8 +: 8] = 8'($urandom);
      endcase
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_px.col = out_col;
      seen_px.row = out_row;
      seen_px.px = {out_red, out_green, out_blue};
      seen_px.run_last = out_run_last;
      seen_px.frame_done = out_frame_done;
      if (upscaled_px_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("Unexpected word: col %0d row %0d rgb %06h last %b done %b",
                   seen_px.col, seen_px.row, seen_px.px, seen_px.run_last,
                   seen_px.frame_done);
      end else begin
        want_px = upscaled_px_q.pop_front();
        words_checked++;
        if (seen_px !== want_px) begin
          err_count++;
          if (err_count <= 10)
            $display("Mismatch: expected col %0d row %0d rgb %06h last %b done %b, %s",
                     want_px.col, want_px.row, want_px.px, want_px.run_last,
                     want_px.frame_done,
                     $sformatf("got col %0d row %0d rgb %06h last %b done %b",
                               seen_px.col, seen_px.row, seen_px.px,
                               seen_px.run_last, seen_px.frame_done));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_pixel(input bup2_pkg::pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red <= p[23:16];
    in_green <= p[15:8];
    in_blue <= p[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    upscale_pixel(p);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (upscaled_px_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bup2_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bup2_pkg::DIM_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, value);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(bup2_pkg::CFG_IMAGE_WIDTH, 11'(w));
    write_reg(bup2_pkg::CFG_IMAGE_HEIGHT, 11'(h));
  endtask

  task automatic send_random(input int n);
    repeat (n) send_pixel(random_pixel());
  endtask

  // The reset size is 640x480, so these are the first pixels of row zero.
  task automatic test_reset_size();
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h55AA55);
  endtask

  task automatic test_channel_extremes();
    bup2_pkg::pix_t tiny [4] = '{24'hFFFFFF, 24'h000000, 24'h0000FF, 24'hFF00FF};
    bup2_pkg::pix_t square [9] = '{24'hAA55AA, 24'hFFFFFF, 24'h010101, 24'hFEFEFE,
                                   24'h80FF00, 24'h00807F, 24'h7F7F7F, 24'h000000,
                                   24'hC0FFEE};
    set_size(2, 2);
    foreach (tiny[i]) send_pixel(tiny[i]);
    set_size(3, 3);
    foreach (square[i]) send_pixel(square[i]);
  endtask

  // Widths below two and a zero height are raised to the smallest legal size.
  task automatic test_size_clamping();
    set_size(0, 0);
    send_pixel(24'hFF8001);
    send_pixel(24'h017FFE);
    set_size(1, 1);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF00FF);
  endtask

  task automatic test_frame_restart();
    set_size(3, 2);
    send_random(2);
    write_reg(CFG_SPARE_A, 11'h7FF);
    write_reg(CFG_SPARE_B, 11'h000);
    send_random(4);
    send_random(2);
    write_reg(bup2_pkg::CFG_IMAGE_WIDTH, 11'd3);
    send_random(6);
  endtask

  task automatic test_random_frames(input int quota);
    int start_count;
    int w;
    int h;
    int ew;
    int eh;
    int n;
    start_count = pixels_sent;
    while (pixels_sent - start_count < quota) begin
      case ($urandom_range(9))
        0: begin
          if ($urandom_range(1)) set_size($urandom_range(1025, 2047), $urandom_range(1, 4));
          else set_size($urandom_range(2, 6), $urandom_range(1025, 2047));
          n = $urandom_range(1, 20);
        end
        1: begin
          n = $urandom_range(1, 12);
        end
        default: begin
          w = ($urandom_range(4) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
          h = $urandom_range(0, 5);
          ew = (w < 2) ? 2 : w;
          eh = (h < 1) ? 1 : h;
          set_size(w, h);
          case ($urandom_range(3))
            0: n = $urandom_range(1, ew * eh);
            1: n = 2 * ew * eh;
            default: n = ew * eh;
          endcase
        end
      endcase
      send_random(n);
    end
  endtask

  task automatic test_widest_frame();
    set_size(bup2_pkg::MAX_WIDTH, 1);
    send_random(EDGE_PIXELS);
  endtask

  task automatic test_tallest_frame();
    set_size(2, 2047);
    send_random(EDGE_PIXELS);
  endtask

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 79;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_channel_extremes();
    test_size_clamping();
    test_frame_restart();
    test_random_frames(40);

    send_idle_pct = 79;
    recv_idle_pct = 33;
    test_widest_frame();
    test_random_frames(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_tallest_frame();
    test_random_frames(30);

    wait_drained();
    $display("Sent %0d pixels with %0d register writes; %0d upscaled words checked.",
             pixels_sent, cfg_writes, words_checked);
    $display("Frame sizes ran from the clamped 2x1 minimum to the 1024 limits, %0d errors.",
             err_count);
    if (err_count == 0) begin
      $display("** bilinear_rgb_upscale_by_two_unit: PASSED **");
    end else begin
      $display("** bilinear_rgb_upscale_by_two_unit: FAILED **");
    end
    $finish;
  end

endmodule
